@@ src/usbcr_pkg.sv @@
// Shared definitions for the endpoint-zero request responder.
// Event and result codes, the queued job record and the descriptor ROM.
// No dependencies.
`default_nettype none

package usbcr_pkg;

    localparam int EP0_PACKET_SIZE_DEF = 8;
    localparam int QUEUE_DEPTH         = 2;

    // Event codes
    localparam logic [2:0] OP_SETUP   = 3'd0;
    localparam logic [2:0] OP_TX_DONE = 3'd1;
    localparam logic [2:0] OP_BUS_RST = 3'd2;
    localparam logic [2:0] OP_SUSPEND = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ZLP    = 2'd2;
    localparam logic [1:0] KIND_STALL  = 2'd3;

    // Link states
    localparam logic [1:0] ST_UNINIT    = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_BUSY      = 2'd2;
    localparam logic [1:0] ST_SUSPENDED = 2'd3;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;

    // Descriptor types
    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_STRING    = 8'd3;
    localparam logic [7:0] DT_QUALIFIER = 8'd6;

    // ROM layout
    localparam logic [6:0] OFF_DEVICE    = 7'd0;
    localparam logic [6:0] OFF_QUALIFIER = 7'd18;
    localparam logic [6:0] OFF_CONFIG    = 7'd28;
    localparam logic [6:0] OFF_LANGS     = 7'd60;
    localparam logic [6:0] OFF_STR1      = 7'd64;
    localparam logic [6:0] OFF_STR2      = 7'd74;
    localparam logic [5:0] SIZE_DEVICE   = 6'd18;
    localparam logic [5:0] SIZE_QUAL     = 6'd10;
    localparam logic [5:0] SIZE_CONFIG   = 6'd32;
    localparam logic [5:0] SIZE_LANGS    = 6'd4;
    localparam logic [5:0] SIZE_STRING   = 6'd10;

    typedef struct packed {
        logic [6:0] device_address;
        logic       address_enabled;
        logic       configured;
        logic [1:0] device_state;
    } usbcr_status_t;

    // One queued answer: a single result, or a packet of cnt data bytes
    typedef struct packed {
        logic [1:0]    kind;
        logic          use_rom;
        logic [6:0]    off;
        logic [6:0]    cnt;
        logic [7:0]    b0;
        logic [7:0]    b1;
        usbcr_status_t status;
    } usbcr_job_t;

    function automatic logic [7:0] rom_byte(input logic [6:0] idx, input logic [6:0] pkt);
        logic [7:0] b;
        begin
            case (idx)
                7'd0:  b = 8'd18;
                7'd1:  b = 8'd1;
                7'd3:  b = 8'h20;
                7'd4:  b = 8'd2;
                7'd7:  b = {1'b0, pkt};
                7'd8:  b = 8'h94;
                7'd9:  b = 8'h06;
                7'd11: b = 8'hFF;
                7'd14: b = 8'd1;
                7'd15: b = 8'd2;
                7'd17: b = 8'd1;
                7'd18: b = 8'd10;
                7'd19: b = 8'd6;
                7'd21: b = 8'h20;
                7'd22: b = 8'd2;
                7'd25: b = {1'b0, pkt};
                7'd26: b = 8'd1;
                7'd28: b = 8'h09;
                7'd29: b = 8'd2;
                7'd30: b = 8'h20;
                7'd32: b = 8'd1;
                7'd33: b = 8'd1;
                7'd35: b = 8'h40;
                7'd37: b = 8'h09;
                7'd38: b = 8'd4;
                7'd41: b = 8'h02;
                7'd42: b = 8'hFF;
                7'd43: b = 8'hFF;
                7'd44: b = 8'hFF;
                7'd46: b = 8'd7;
                7'd47: b = 8'd5;
                7'd48: b = 8'h01;
                7'd49: b = 8'h02;
                7'd50: b = 8'd64;
                7'd53: b = 8'd7;
                7'd54: b = 8'd5;
                7'd55: b = 8'h82;
                7'd56: b = 8'h02;
                7'd57: b = 8'd64;
                7'd60: b = 8'd4;
                7'd61: b = 8'd3;
                7'd62: b = 8'h09;
                7'd63: b = 8'h04;
                7'd64: b = 8'd10;
                7'd65: b = 8'd3;
                7'd66: b = 8'h4C;
                7'd68: b = 8'h45;
                7'd70: b = 8'h47;
                7'd72: b = 8'h4F;
                7'd74: b = 8'd10;
                7'd75: b = 8'd3;
                7'd76: b = 8'h4E;
                7'd78: b = 8'h78;
                7'd80: b = 8'h4F;
                7'd82: b = 8'h53;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/usbcr_front.sv @@
// Front end: accepts bus events, keeps the device state and turns each
// event into one queued job. Depends on usbcr_pkg.
`default_nettype none

module usbcr_front import usbcr_pkg::*; #(
    parameter int EP0_PACKET_SIZE = EP0_PACKET_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [7:0]  s_request_type,
    input  wire logic [7:0]  s_request_code,
    input  wire logic [15:0] s_request_value,
    input  wire logic [15:0] s_request_length,
    input  wire logic [1:0]  s_endpoint_number,
    input  wire logic        q_full,
    output logic             s_ready,
    output logic             q_push,
    output usbcr_job_t       q_job
);

    localparam logic [6:0] PKT = 7'(EP0_PACKET_SIZE);

    logic [1:0] link_reg,   link_next;
    logic [1:0] saved_reg,  saved_next;
    logic [6:0] pend_reg,   pend_next;
    logic [6:0] addr_reg,   addr_next;
    logic       aflag_reg,  aflag_next;
    logic [7:0] cfg_reg,    cfg_next;
    logic [6:0] soff_reg,   soff_next;
    logic [5:0] srem_reg,   srem_next;
    logic       zdue_reg,   zdue_next;

    logic       desc_ok;
    logic [6:0] desc_off;
    logic [5:0] desc_size;
    logic [5:0] desc_len;
    logic [6:0] rom_off;
    logic [5:0] rom_len;
    logic [6:0] pkt;
    logic [6:0] rest;
    logic [1:0] small_len;
    logic       cfg_len;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Descriptor lookup
    always_comb begin
        desc_ok   = 1'b1;
        desc_off  = OFF_DEVICE;
        desc_size = SIZE_DEVICE;
        case (s_request_value[15:8])
            DT_DEVICE: begin
                desc_off  = OFF_DEVICE;
                desc_size = SIZE_DEVICE;
            end
            DT_CONFIG: begin
                desc_off  = OFF_CONFIG;
                desc_size = SIZE_CONFIG;
            end
            DT_STRING: begin
                desc_size = SIZE_STRING;
                case (s_request_value[7:0])
                    8'd0: begin
                        desc_off  = OFF_LANGS;
                        desc_size = SIZE_LANGS;
                    end
                    8'd1:    desc_off = OFF_STR1;
                    8'd2:    desc_off = OFF_STR2;
                    default: desc_ok  = 1'b0;
                endcase
            end
            DT_QUALIFIER: begin
                desc_off  = OFF_QUALIFIER;
                desc_size = SIZE_QUAL;
            end
            default: desc_ok = 1'b0;
        endcase
        desc_len = (16'(desc_size) < s_request_length) ? desc_size : s_request_length[5:0];
    end

    // Packet split shared by descriptor reads and continuation packets
    always_comb begin
        if (s_opcode == OP_SETUP) begin
            rom_off = desc_off;
            rom_len = desc_len;
        end else begin
            rom_off = soff_reg;
            rom_len = srem_reg;
        end
        pkt  = ({1'b0, rom_len} < PKT) ? {1'b0, rom_len} : PKT;
        rest = {1'b0, rom_len} - pkt;
    end

    assign small_len = (s_request_length < 16'd2) ? s_request_length[1:0] : 2'd2;
    assign cfg_len   = (s_request_length != 16'd0);

    always_comb begin
        link_next  = link_reg;
        saved_next = saved_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        aflag_next = aflag_reg;
        cfg_next   = cfg_reg;
        soff_next  = soff_reg;
        srem_next  = srem_reg;
        zdue_next  = zdue_reg;
        q_job         = '0;
        q_job.kind    = KIND_STATUS;
        q_job.cnt     = 7'd1;

        case (s_opcode)
            OP_SETUP: begin
                // a setup drops any continuation packets and padding still owed
                soff_next = '0;
                srem_next = '0;
                zdue_next = 1'b0;
                case (s_request_code)
                    REQ_GET_STATUS: begin
                        link_next = ST_BUSY;
                        if (small_len == 2'd0) begin
                            q_job.kind = KIND_ZLP;
                        end else begin
                            q_job.kind = KIND_DATA;
                            q_job.cnt  = {5'd0, small_len};
                            q_job.b0   = {7'd0, (s_request_type[3:0] == 4'd0)};
                        end
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_IFACE: begin
                        link_next  = ST_BUSY;
                        q_job.kind = KIND_ZLP;
                    end
                    REQ_SET_ADDRESS: begin
                        link_next  = ST_BUSY;
                        q_job.kind = KIND_ZLP;
                        pend_next  = s_request_value[6:0];
                        if (s_request_value[6:0] == 7'd0) begin
                            addr_next  = '0;
                            aflag_next = 1'b0;
                        end
                    end
                    REQ_GET_DESC: begin
                        if (!desc_ok) begin
                            link_next  = ST_UNINIT;
                            q_job.kind = KIND_STALL;
                        end else begin
                            link_next = ST_BUSY;
                            if (rest != 7'd0) begin
                                soff_next = rom_off + pkt;
                                srem_next = rest[5:0];
                            end
                            if (pkt == 7'd0) begin
                                q_job.kind = KIND_ZLP;
                            end else begin
                                q_job.kind    = KIND_DATA;
                                q_job.use_rom = 1'b1;
                                q_job.off     = rom_off;
                                q_job.cnt     = pkt;
                            end
                            // pad with a zero-length packet after the full configuration
                            if (s_request_value[15:8] == DT_CONFIG
                                && s_request_length > 16'(SIZE_CONFIG)) begin
                                zdue_next = 1'b1;
                            end
                        end
                    end
                    REQ_GET_CONFIG: begin
                        link_next = ST_BUSY;
                        if (!cfg_len) begin
                            q_job.kind = KIND_ZLP;
                        end else begin
                            q_job.kind = KIND_DATA;
                            q_job.b0   = cfg_reg;
                        end
                    end
                    REQ_SET_CONFIG: begin
                        cfg_next   = s_request_value[7:0];
                        link_next  = ST_READY;
                        q_job.kind = KIND_ZLP;
                    end
                    default: begin
                        link_next  = ST_UNINIT;
                        q_job.kind = KIND_STALL;
                    end
                endcase
            end
            OP_TX_DONE: begin
                link_next = ST_READY;
                // apply the new address once its acknowledge has gone out
                if (pend_reg != 7'd0) begin
                    addr_next  = pend_reg;
                    aflag_next = 1'b1;
                    pend_next  = '0;
                end
                if (s_endpoint_number == 2'd0 && srem_reg != 6'd0) begin
                    link_next = ST_BUSY;
                    if (rest != 7'd0) begin
                        soff_next = rom_off + pkt;
                        srem_next = rest[5:0];
                    end else begin
                        soff_next = '0;
                        srem_next = '0;
                    end
                    q_job.kind    = KIND_DATA;
                    q_job.use_rom = 1'b1;
                    q_job.off     = rom_off;
                    q_job.cnt     = pkt;
                end else if (s_endpoint_number == 2'd0 && zdue_reg) begin
                    zdue_next  = 1'b0;
                    link_next  = ST_BUSY;
                    soff_next  = '0;
                    srem_next  = '0;
                    q_job.kind = KIND_ZLP;
                end
            end
            OP_BUS_RST: begin
                link_next  = ST_UNINIT;
                pend_next  = '0;
                addr_next  = '0;
                aflag_next = 1'b0;
                cfg_next   = '0;
                soff_next  = '0;
                srem_next  = '0;
                zdue_next  = 1'b0;
            end
            OP_SUSPEND: begin
                saved_next = link_reg;
                link_next  = ST_SUSPENDED;
            end
            OP_RESUME: begin
                link_next = saved_reg;
            end
            default: begin
            end
        endcase

        q_job.status.device_address  = addr_next;
        q_job.status.address_enabled = aflag_next;
        q_job.status.configured      = (cfg_next != 8'd0);
        q_job.status.device_state    = link_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg  <= ST_UNINIT;
            saved_reg <= ST_UNINIT;
            pend_reg  <= '0;
            addr_reg  <= '0;
            aflag_reg <= 1'b0;
            cfg_reg   <= '0;
            soff_reg  <= '0;
            srem_reg  <= '0;
            zdue_reg  <= 1'b0;
        end else if (q_push) begin
            link_reg  <= link_next;
            saved_reg <= saved_next;
            pend_reg  <= pend_next;
            addr_reg  <= addr_next;
            aflag_reg <= aflag_next;
            cfg_reg   <= cfg_next;
            soff_reg  <= soff_next;
            srem_reg  <= srem_next;
            zdue_reg  <= zdue_next;
        end
    end

endmodule

`default_nettype wire

@@ src/usbcr_job_queue.sv @@
// Short job queue between the front and back ends.
// Depends on usbcr_pkg for the job record and depth.
`default_nettype none

module usbcr_job_queue import usbcr_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire usbcr_job_t push_job,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output usbcr_job_t      head_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    usbcr_job_t     slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");

    a_pop_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(1) && do_pop && !do_push) |=> !not_empty)
        else $error("job queue not empty after last pop");

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(QUEUE_DEPTH - 1) && do_push && !do_pop) |=> full)
        else $error("job queue not full after filling push");

endmodule

`default_nettype wire

@@ src/usbcr_back.sv @@
// Back end: takes jobs from the queue and sends their results, one per packet byte or a
// single one for other kinds, with bytes from the descriptor ROM or the job. Depends on usbcr_pkg.
`default_nettype none

module usbcr_back import usbcr_pkg::*; #(
    parameter int EP0_PACKET_SIZE = EP0_PACKET_SIZE_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_not_empty,
    input  wire usbcr_job_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [7:0]      m_data_byte,
    output logic            m_last_of_run,
    output logic [6:0]      m_device_address,
    output logic            m_address_enabled,
    output logic            m_configured,
    output logic [1:0]      m_device_state
);

    localparam logic [6:0] PKT = 7'(EP0_PACKET_SIZE);

    usbcr_job_t     job_reg;
    logic           busy_reg;
    logic [5:0]     idx_reg;
    logic           m_valid_reg;
    logic [1:0]     kind_reg;
    logic [7:0]     byte_reg;
    logic           last_reg;
    usbcr_status_t  status_reg;

    logic           out_load;
    logic           last;
    logic [7:0]     next_byte;

    assign q_pop    = !busy_reg && q_not_empty;
    assign out_load = busy_reg && (!m_valid_reg || m_ready);
    assign last     = ({1'b0, idx_reg} + 7'd1 == job_reg.cnt);

    always_comb begin
        if (job_reg.kind != KIND_DATA) begin
            next_byte = 8'h00;
        end else if (job_reg.use_rom) begin
            next_byte = rom_byte(job_reg.off + {1'b0, idx_reg}, PKT);
        end else begin
            next_byte = idx_reg[0] ? job_reg.b1 : job_reg.b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
        if (out_load) begin
            kind_reg   <= job_reg.kind;
            byte_reg   <= next_byte;
            last_reg   <= last;
            status_reg <= job_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (out_load) begin
                // advance through the packet, release the job on its last byte
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_data_byte       = byte_reg;
    assign m_last_of_run     = last_reg;
    assign m_device_address  = status_reg.device_address;
    assign m_address_enabled = status_reg.address_enabled;
    assign m_configured      = status_reg.configured;
    assign m_device_state    = status_reg.device_state;

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg != KIND_DATA) |-> (last_reg && byte_reg == 8'h00))
        else $error("single result not marked last or carries a byte");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, idx_reg} < job_reg.cnt))
        else $error("packet index past job length");

    a_release_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && out_load && last) |=> (!busy_reg && m_valid_reg && last_reg))
        else $error("job not released after its last result");

endmodule

`default_nettype wire

@@ src/usb_control_request_responder.sv @@
// Endpoint-zero standard request responder, top level.
// An accepted event is written into the job queue, the back end loads it into its job register,
// and each result is registered at the output. The back end fetches a job only when idle, then
// gives one result per cycle while the receiver keeps m_ready high, so a packet is at most
// EP0_PACKET_SIZE bytes; the front end takes an event whenever the two-entry job queue has room.
// Reset (aresetn low, synchronous): device state, addresses, configuration
// and the send queue clear; no results are pending.
`default_nettype none

module usb_control_request_responder import usbcr_pkg::*; #(
    parameter int EP0_PACKET_SIZE = EP0_PACKET_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [7:0]  s_request_type,
    input  wire logic [7:0]  s_request_code,
    input  wire logic [15:0] s_request_value,
    input  wire logic [15:0] s_request_length,
    input  wire logic [1:0]  s_endpoint_number,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_data_byte,
    output logic             m_last_of_run,
    output logic [6:0]       m_device_address,
    output logic             m_address_enabled,
    output logic             m_configured,
    output logic [1:0]       m_device_state
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    usbcr_job_t push_job;
    usbcr_job_t head_job;

    usbcr_front #(
        .EP0_PACKET_SIZE (EP0_PACKET_SIZE)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_opcode          (s_opcode),
        .s_request_type    (s_request_type),
        .s_request_code    (s_request_code),
        .s_request_value   (s_request_value),
        .s_request_length  (s_request_length),
        .s_endpoint_number (s_endpoint_number),
        .q_full            (q_full),
        .s_ready           (s_ready),
        .q_push            (q_push),
        .q_job             (push_job)
    );

    usbcr_job_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    usbcr_back #(
        .EP0_PACKET_SIZE (EP0_PACKET_SIZE)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_not_empty       (q_not_empty),
        .q_head            (head_job),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_data_byte       (m_data_byte),
        .m_last_of_run     (m_last_of_run),
        .m_device_address  (m_device_address),
        .m_address_enabled (m_address_enabled),
        .m_configured      (m_configured),
        .m_device_state    (m_device_state)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the endpoint-zero request responder.
// Drives bus events, predicts every answer and compares it field by field.
// Depends on usbcr_pkg and usb_control_request_responder.
`timescale 1ns / 1ps

module tb_top;
    import usbcr_pkg::*;

    localparam logic [6:0] PKT = 7'd8;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] addr;
        logic       addr_en;
        logic       cfg;
        logic [1:0] state;
    } answer_t;

    // Tracks the device as it should be and queues the answers it owes.
    class ep0_scoreboard;
        logic [7:0] rom [84];
        logic [1:0] link, saved_link;
        logic [6:0] pend_addr, act_addr, send_off;
        logic       addr_en, zlp_due;
        logic [7:0] sel_cfg;
        logic [5:0] send_rem;
        answer_t    run[$];
        answer_t    expected_answers[$];
        int         failures;

        function new();
            // Device, qualifier, configuration, languages, strings 1 and 2
            rom = '{8'h12, 8'h01, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00, 8'h08, 8'h94, 8'h06,
                    8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
                    8'h0A, 8'h06, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00, 8'h08, 8'h01, 8'h00,
                    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h40, 8'h00,
                    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                    8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
                    8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
                    8'h04, 8'h03, 8'h09, 8'h04,
                    8'h0A, 8'h03, 8'h4C, 8'h00, 8'h45, 8'h00, 8'h47, 8'h00, 8'h4F, 8'h00,
                    8'h0A, 8'h03, 8'h4E, 8'h00, 8'h78, 8'h00, 8'h4F, 8'h00, 8'h53, 8'h00};
            link = ST_UNINIT;
            saved_link = ST_UNINIT;
            pend_addr = 7'd0;
            act_addr = 7'd0;
            addr_en = 1'b0;
            sel_cfg = 8'd0;
            send_off = 7'd0;
            send_rem = 6'd0;
            zlp_due = 1'b0;
            failures = 0;
        endfunction

        function void add(input logic [1:0] kind, input logic [7:0] data);
            answer_t r;
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            r.addr = 7'd0;
            r.addr_en = 1'b0;
            r.cfg = 1'b0;
            r.state = ST_UNINIT;
            run.push_back(r);
        endfunction

        // One packet from the descriptor ROM; queue whatever does not fit
        function void send_rom(input logic [6:0] off, input logic [6:0] len);
            logic [6:0] pkt;
            logic [6:0] i;
            pkt = (len < PKT) ? len : PKT;
            link = ST_BUSY;
            if (len > pkt) begin
                send_off = off + pkt;
                send_rem = len[5:0] - pkt[5:0];
            end else begin
                send_off = 7'd0;
                send_rem = 6'd0;
            end
            if (pkt == 7'd0)
                add(KIND_ZLP, 8'd0);
            for (i = 7'd0; i < pkt; i++)
                add(KIND_DATA, (off + i < 7'd84) ? rom[off + i] : 8'd0);
        endfunction

        function void send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [1:0] size, input logic [15:0] wlen);
            link = ST_BUSY;
            send_off = 7'd0;
            send_rem = 6'd0;
            if (wlen == 16'd0) begin
                add(KIND_ZLP, 8'd0);
            end else begin
                add(KIND_DATA, b0);
                if (size == 2'd2 && wlen > 16'd1)
                    add(KIND_DATA, b1);
            end
        endfunction

        function void send_zlp();
            link = ST_BUSY;
            send_off = 7'd0;
            send_rem = 6'd0;
            add(KIND_ZLP, 8'd0);
        endfunction

        function void stall();
            link = ST_UNINIT;
            send_off = 7'd0;
            send_rem = 6'd0;
            zlp_due = 1'b0;
            add(KIND_STALL, 8'd0);
        endfunction

        function void note_event(input logic [2:0] op, input logic [7:0] rtype,
                                 input logic [7:0] code, input logic [15:0] value,
                                 input logic [15:0] wlen, input logic [1:0] ep);
            logic [6:0] off, size;
            logic       known;
            run.delete();
            case (op)
                OP_SETUP: begin
                    // a setup always drops any continuation packets and padding still owed
                    send_off = 7'd0;
                    send_rem = 6'd0;
                    zlp_due = 1'b0;
                    case (code)
                        REQ_GET_STATUS:
                            send_bytes((rtype[3:0] == 4'd0) ? 8'd1 : 8'd0, 8'd0, 2'd2, wlen);
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_IFACE:
                            send_zlp();
                        REQ_SET_ADDRESS: begin
                            pend_addr = value[6:0];
                            send_zlp();
                            if (value[6:0] == 7'd0) begin
                                act_addr = 7'd0;
                                addr_en = 1'b0;
                            end
                        end
                        REQ_GET_DESC: begin
                            known = 1'b1;
                            off = 7'd0;
                            size = 7'd0;
                            case (value[15:8])
                                DT_DEVICE: begin
                                    off = OFF_DEVICE;
                                    size = {1'b0, SIZE_DEVICE};
                                end
                                DT_CONFIG: begin
                                    off = OFF_CONFIG;
                                    size = {1'b0, SIZE_CONFIG};
                                end
                                DT_QUALIFIER: begin
                                    off = OFF_QUALIFIER;
                                    size = {1'b0, SIZE_QUAL};
                                end
                                DT_STRING: begin
                                    case (value[7:0])
                                        8'd0: begin
                                            off = OFF_LANGS;
                                            size = {1'b0, SIZE_LANGS};
                                        end
                                        8'd1: begin
                                            off = OFF_STR1;
                                            size = {1'b0, SIZE_STRING};
                                        end
                                        8'd2: begin
                                            off = OFF_STR2;
                                            size = {1'b0, SIZE_STRING};
                                        end
                                        default: known = 1'b0;
                                    endcase
                                end
                                default: known = 1'b0;
                            endcase
                            if (!known) begin
                                stall();
                            end else begin
                                send_rom(off, ({9'd0, size} < wlen) ? size : wlen[6:0]);
                                // host asked for more than the full set: pad with a ZLP
                                if (value[15:8] == DT_CONFIG && wlen > {10'd0, SIZE_CONFIG})
                                    zlp_due = 1'b1;
                            end
                        end
                        REQ_GET_CONFIG:
                            send_bytes(sel_cfg, 8'd0, 2'd1, wlen);
                        REQ_SET_CONFIG: begin
                            sel_cfg = value[7:0];
                            send_zlp();
                            link = ST_READY;
                        end
                        default:
                            stall();
                    endcase
                end
                OP_TX_DONE: begin
                    link = ST_READY;
                    if (pend_addr != 7'd0) begin
                        act_addr = pend_addr;
                        addr_en = 1'b1;
                        pend_addr = 7'd0;
                    end
                    if (ep == 2'd0 && send_rem != 6'd0) begin
                        send_rom(send_off, {1'b0, send_rem});
                    end else if (ep == 2'd0 && zlp_due) begin
                        zlp_due = 1'b0;
                        send_zlp();
                    end else begin
                        add(KIND_STATUS, 8'd0);
                    end
                end
                OP_BUS_RST: begin
                    link = ST_UNINIT;
                    pend_addr = 7'd0;
                    act_addr = 7'd0;
                    addr_en = 1'b0;
                    sel_cfg = 8'd0;
                    send_off = 7'd0;
                    send_rem = 6'd0;
                    zlp_due = 1'b0;
                    add(KIND_STATUS, 8'd0);
                end
                OP_SUSPEND: begin
                    saved_link = link;
                    link = ST_SUSPENDED;
                    add(KIND_STATUS, 8'd0);
                end
                OP_RESUME: begin
                    link = saved_link;
                    add(KIND_STATUS, 8'd0);
                end
                default:
                    add(KIND_STATUS, 8'd0);
            endcase
            foreach (run[k]) begin
                run[k].last = (k == run.size() - 1);
                run[k].addr = act_addr;
                run[k].addr_en = addr_en;
                run[k].cfg = (sel_cfg != 8'd0);
                run[k].state = link;
                expected_answers.push_back(run[k]);
            end
        endfunction

        function void match_field(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_answer(input logic [1:0] kind, input logic [7:0] data,
                                   input logic last, input logic [6:0] addr,
                                   input logic addr_on, input logic cfg,
                                   input logic [1:0] state);
            answer_t w;
            if (expected_answers.size() == 0) begin
                $error("result_kind: expected nothing, got %0d", kind);
                failures++;
            end else begin
                w = expected_answers.pop_front();
                match_field("result_kind", {6'd0, w.kind}, {6'd0, kind});
                match_field("data_byte", w.data, data);
                match_field("last_of_run", {7'd0, w.last}, {7'd0, last});
                match_field("device_address", {1'b0, w.addr}, {1'b0, addr});
                match_field("address_enabled", {7'd0, w.addr_en}, {7'd0, addr_on});
                match_field("configured", {7'd0, w.cfg}, {7'd0, cfg});
                match_field("device_state", {6'd0, w.state}, {6'd0, state});
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_opcode;
    logic [7:0]  s_request_type;
    logic [7:0]  s_request_code;
    logic [15:0] s_request_value;
    logic [15:0] s_request_length;
    logic [1:0]  s_endpoint_number;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_data_byte;
    logic        m_last_of_run;
    logic [6:0]  m_device_address;
    logic        m_address_enabled;
    logic        m_configured;
    logic [1:0]  m_device_state;

    ep0_scoreboard answers;
    int            events_sent;

    usb_control_request_responder u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_request_type    (s_request_type),
        .s_request_code    (s_request_code),
        .s_request_value   (s_request_value),
        .s_request_length  (s_request_length),
        .s_endpoint_number (s_endpoint_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_data_byte       (m_data_byte),
        .m_last_of_run     (m_last_of_run),
        .m_device_address  (m_device_address),
        .m_address_enabled (m_address_enabled),
        .m_configured      (m_configured),
        .m_device_state    (m_device_state)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(input logic [2:0] op, input logic [7:0] rtype,
                              input logic [7:0] code, input logic [15:0] value,
                              input logic [15:0] wlen, input logic [1:0] ep);
        while (!(events_sent >= 180 && events_sent < 240) && $urandom_range(0, 99) < 22) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_request_type = rtype;
        s_request_code = code;
        s_request_value = value;
        s_request_length = wlen;
        s_endpoint_number = ep;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        answers.note_event(op, rtype, code, value, wlen, ep);
        events_sent++;
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off, one quiet stretch
    initial begin
        int  hold;
        bit  held;
        hold = 0;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && events_sent >= 120) begin
                held = 1'b1;
                hold = 150;
            end
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else if (events_sent >= 180 && events_sent < 240) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(0, 99) >= 22);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            answers.check_answer(m_result_kind, m_data_byte, m_last_of_run, m_device_address,
                                 m_address_enabled, m_configured, m_device_state);
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [31:0] rnd, rnd2;
        logic [2:0]  op;
        logic [7:0]  rtype, code;
        logic [15:0] value, wlen;
        logic [1:0]  ep;
        int          pick;
        int          guard;

        answers = new();
        events_sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_SETUP;
        s_request_type = 8'd0;
        s_request_code = 8'd0;
        s_request_value = 16'd0;
        s_request_length = 16'd0;
        s_endpoint_number = 2'd0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: each request, the length limits, padding, aborts, suspend
        send_event(OP_BUS_RST, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_STATUS, 16'h0000, 16'hFFFF, 2'd0);
        send_event(OP_SETUP, 8'h8F, REQ_GET_STATUS, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0040, 2'd0);
        send_event(OP_TX_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_TX_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_TX_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'hFFFF, 2'd0);
        repeat (5) send_event(OP_TX_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'h03}, 16'h00FF, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'h00}, 16'h00FF, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'h01}, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'h02}, 16'h0003, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_QUALIFIER, 8'h00}, 16'h000A, 2'd0);
        // setup in the middle of a transfer drops the rest of it
        send_event(OP_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFFAA, 16'h0000, 2'd0);
        send_event(OP_TX_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd3);
        send_event(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0700, 16'h0012, 2'd0);
        send_event(OP_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0005, 2'd0);
        send_event(OP_SETUP, 8'h02, REQ_CLEAR_FEATURE, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h01, REQ_SET_IFACE, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 2'd0);
        send_event(OP_SUSPEND, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_RESUME, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(3'd7, 8'h00, 8'h00, 16'h0000, 16'h0000, 2'd0);
        send_event(OP_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFF80, 16'h0000, 2'd0);

        // Random: mostly descriptor reads drained by transmit completes
        repeat (300) begin
            rnd = $urandom;
            rnd2 = $urandom;
            rtype = rnd[7:0];
            code = rnd[15:8];
            value = rnd[31:16];
            wlen = rnd2[15:0];
            ep = rnd2[17:16];
            op = rnd2[20:18];
            // keep most lengths near the descriptor sizes
            if (rnd2[27:21] < 7'd90)
                wlen = {10'd0, rnd2[31:26]};
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                op = OP_TX_DONE;
                if (pick < 27)
                    ep = 2'd0;
            end else if (pick < 60) begin
                op = OP_SETUP;
                code = REQ_GET_DESC;
                case ($urandom_range(0, 4))
                    0: value[15:8] = DT_DEVICE;
                    1: value[15:8] = DT_CONFIG;
                    2: value[15:8] = DT_STRING;
                    3: value[15:8] = DT_QUALIFIER;
                    default: ;
                endcase
                if ($urandom_range(0, 4) != 0)
                    value[7:0] = {6'd0, rnd2[25:24]};
            end else if (pick < 72) begin
                op = OP_SETUP;
                case ($urandom_range(0, 5))
                    0: code = REQ_GET_STATUS;
                    1: code = REQ_CLEAR_FEATURE;
                    2: code = REQ_SET_FEATURE;
                    3: code = REQ_GET_CONFIG;
                    4: code = REQ_SET_CONFIG;
                    default: code = REQ_SET_IFACE;
                endcase
            end else if (pick < 78) begin
                op = OP_SETUP;
                code = REQ_SET_ADDRESS;
            end else if (pick < 82) begin
                op = OP_SETUP;
            end else if (pick < 86) begin
                op = OP_BUS_RST;
            end else if (pick < 91) begin
                op = OP_SUSPEND;
            end else if (pick < 96) begin
                op = OP_RESUME;
            end
            send_event(op, rtype, code, value, wlen, ep);
        end
        s_valid = 1'b0;

        guard = 0;
        while (answers.expected_answers.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (answers.expected_answers.size() != 0) begin
            $error("result_kind: %0d results never arrived", answers.expected_answers.size());
            answers.failures++;
        end
        if (answers.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
